// ===== rtl/mdfb_pkg.sv =====
// Shared constants, types and codes of the monochrome display framebuffer.
package mdfb_pkg;

    localparam int COLUMNS    = 128;
    localparam int PAGES      = 8;
    localparam int HEAD_STEPS = 3;

    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ADDR_W  = COL_W + PAGE_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int STEP_W  = $clog2(COLUMNS + HEAD_STEPS);

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    // input command codes
    localparam logic [2:0] OP_DRAW     = 3'd0;
    localparam logic [2:0] OP_CLR_PAGE = 3'd1;
    localparam logic [2:0] OP_CLR_ALL  = 3'd2;
    localparam logic [2:0] OP_REFRESH  = 3'd3;
    localparam logic [2:0] OP_NEXT     = 3'd4;

    // register indexes (word address)
    localparam logic REG_COL_OFFSET = 1'b0;
    localparam logic [7:0] COL_OFFSET_RESET = 8'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DRAW_WR,
        ST_CLR_PAGE,
        ST_CLR_ALL,
        ST_BYTE
    } mdfb_state_t;

    typedef enum logic [1:0] {
        WS_DRAW,
        WS_PAGE,
        WS_ALL
    } mdfb_wsel_t;

    typedef struct packed {
        logic       accept;
        logic       rd_en;
        logic       we;
        mdfb_wsel_t wsel;
        logic       sweep_en;
        logic       arm;
        logic       load_out;
    } mdfb_cmd_t;

    typedef struct packed {
        logic [2:0] in_op;
        logic       point_ok;
        logic       page_ok;
        logic       sweep_done;
        logic       scan_active;
        logic       out_free;
    } mdfb_status_t;

endpackage

// ===== rtl/mono_display_framebuffer_top.sv =====
// Top level of the monochrome display framebuffer: register port, controller and datapath.
//
// Page-mode framebuffer for a COLUMNS x (PAGES*8) monochrome panel (128x64).
// s_ channel: one item per command (draw point, clear page, clear screen,
// start refresh, next byte). Only a next byte during an active refresh
// yields an item on the m_ channel: the page command, two column address
// commands from column_offset, then one data byte per column; m_tuser marks
// data bytes and m_tlast the final data byte of the last page.
// Steps: a draw point and a next byte each do one store read when taken,
// then the write or, in ST_BYTE, the output load; m_tvalid rises once that
// load has set the output register. A clear page walks one page; a clear
// screen walks the whole store, then arms a refresh. Start refresh, an
// ignored draw or clear page and an unknown command go straight back to idle.
// After reset the store is swept to zero while s_tready stays low;
// the register port works throughout. The result sits in an output register:
// while m_tready is low it holds and other commands go on being taken, but a
// next byte behind it waits in the block with s_tready low until it drains.
// column_offset sits at byte address 0 of the APB port, reset value 2.
module mono_display_framebuffer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // command(3) x_pos(8) y_pos(8) pixel_on(1) page_sel(4), from bit 0 up
    input  logic [23:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // link_byte(8)
    output logic [7:0]  m_tdata,
    // is_data(1)
    output logic        m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mdfb_pkg::*;

    logic [7:0]   col_offset_reg;
    logic         cfg_wr;
    mdfb_cmd_t    cmd;
    mdfb_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_COL_OFFSET);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_offset_reg <= COL_OFFSET_RESET;
        end else if (cfg_wr) begin
            col_offset_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_COL_OFFSET) ? {24'h0, col_offset_reg} : 32'h0;

    mdfb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mdfb_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .col_offset (col_offset_reg),
        .cmd        (cmd),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // a result is loaded only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over a pending item");

    // store writes never overlap taking an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.we |-> !s_tready)
        else $error("store write while accepting");

    // the end-of-frame byte is always a data byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("frame end on a command byte");

    // arming a refresh makes the scan active
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.arm |=> status.scan_active)
        else $error("refresh armed but scan idle");

endmodule

// ===== rtl/mdfb_ctrl.sv =====
// Controller state machine of the display framebuffer.
module mdfb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mdfb_pkg::mdfb_status_t status,
    output mdfb_pkg::mdfb_cmd_t    cmd
);
    import mdfb_pkg::*;

    mdfb_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (status.sweep_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (status.in_op)
                        OP_DRAW:     state_next = status.point_ok ? ST_DRAW_WR : ST_IDLE;
                        OP_CLR_PAGE: state_next = status.page_ok ? ST_CLR_PAGE : ST_IDLE;
                        OP_CLR_ALL:  state_next = ST_CLR_ALL;
                        OP_NEXT:     state_next = ST_BYTE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DRAW_WR: state_next = ST_IDLE;
            ST_CLR_PAGE, ST_CLR_ALL: begin
                if (status.sweep_done) state_next = ST_IDLE;
            end
            ST_BYTE: begin
                if (!status.scan_active || status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.wsel = WS_ALL;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.we       = 1'b1;
                cmd.sweep_en = 1'b1;
            end
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.accept = s_tvalid;
                cmd.arm    = s_tvalid && (status.in_op == OP_REFRESH);
            end
            ST_DRAW_WR: begin
                cmd.we   = 1'b1;
                cmd.wsel = WS_DRAW;
            end
            ST_CLR_PAGE: begin
                cmd.we       = 1'b1;
                cmd.wsel     = WS_PAGE;
                cmd.sweep_en = 1'b1;
            end
            ST_CLR_ALL: begin
                cmd.we       = 1'b1;
                cmd.sweep_en = 1'b1;
                cmd.arm      = status.sweep_done;
            end
            ST_BYTE: begin
                cmd.load_out = status.scan_active && status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/mdfb_datapath.sv =====
// Datapath: frame store, clear sweep counter, refresh scan counters, output register.
module mdfb_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [23:0]            s_tdata,
    input  logic [7:0]             col_offset,
    input  mdfb_pkg::mdfb_cmd_t    cmd,
    output mdfb_pkg::mdfb_status_t status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import mdfb_pkg::*;

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COLUMNS + HEAD_STEPS - 1);
    localparam logic [STEP_W-1:0] STEP_HEAD = STEP_W'(HEAD_STEPS);

    logic [7:0] mem [DEPTH];

    // live input fields
    logic [2:0] in_op;
    logic [7:0] in_x, in_y;
    logic       in_on;
    logic [3:0] in_page;

    assign in_op   = s_tdata[2:0];
    assign in_x    = s_tdata[10:3];
    assign in_y    = s_tdata[18:11];
    assign in_on   = s_tdata[19];
    assign in_page = s_tdata[23:20];

    logic [PAGE_W-1:0] pix_page;
    logic [ADDR_W-1:0] pix_addr;
    logic [7:0]        pix_mask;

    // vertical flip: row y lands in page PAGES-1-y/8, bit 7-y%8
    assign pix_page = PAGE_LAST - in_y[PAGE_W+2:3];
    assign pix_addr = {in_x[COL_W-1:0], pix_page};
    assign pix_mask = 8'h80 >> in_y[2:0];

    // latched item fields
    logic [ADDR_W-1:0] draw_addr_reg;
    logic [7:0]        draw_mask_reg;
    logic              draw_on_reg;
    logic [PAGE_W-1:0] clr_page_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            draw_addr_reg <= pix_addr;
            draw_mask_reg <= pix_mask;
            draw_on_reg   <= in_on;
            clr_page_reg  <= in_page[PAGE_W-1:0];
        end
    end

    // set while the sweep walks a single page
    logic sweep_page_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_page_reg <= 1'b0;
        end else if (cmd.accept) begin
            sweep_page_reg <= (in_op == OP_CLR_PAGE);
        end
    end

    // sweep counter for page and full clears
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              sweep_done;

    assign sweep_done = sweep_page_reg ? (sweep_reg[COL_W-1:0] == COL_LAST)
                                       : (sweep_reg == ADDR_LAST);

    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.sweep_en) begin
            sweep_next = sweep_done ? '0 : sweep_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else begin
            sweep_reg <= sweep_next;
        end
    end

    // refresh scan
    logic              scan_active_reg, scan_active_next;
    logic [PAGE_W-1:0] scan_page_reg, scan_page_next;
    logic [STEP_W-1:0] scan_step_reg, scan_step_next;
    logic [STEP_W-1:0] scan_col_full;
    logic [ADDR_W-1:0] scan_addr;

    assign scan_col_full = scan_step_reg - STEP_HEAD;
    assign scan_addr     = {scan_col_full[COL_W-1:0], scan_page_reg};

    always_comb begin
        scan_active_next = scan_active_reg;
        scan_page_next   = scan_page_reg;
        scan_step_next   = scan_step_reg;
        if (cmd.arm) begin
            scan_active_next = 1'b1;
            scan_page_next   = '0;
            scan_step_next   = '0;
        end else if (cmd.load_out) begin
            scan_step_next = scan_step_reg + 1'b1;
            if (scan_step_reg == STEP_LAST) begin
                scan_step_next = '0;
                if (scan_page_reg == PAGE_LAST) begin
                    scan_active_next = 1'b0;
                    scan_page_next   = '0;
                end else begin
                    scan_page_next = scan_page_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_active_reg <= 1'b0;
            scan_page_reg   <= '0;
            scan_step_reg   <= '0;
        end else begin
            scan_active_reg <= scan_active_next;
            scan_page_reg   <= scan_page_next;
            scan_step_reg   <= scan_step_next;
        end
    end

    // frame store
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [7:0]        rd_data_reg, wr_data;

    // a draw reads its byte in the accept cycle; otherwise the scan byte is fetched
    assign rd_addr = (in_op == OP_DRAW) ? pix_addr : scan_addr;

    always_comb begin
        wr_addr = sweep_reg;
        wr_data = 8'h00;
        unique case (cmd.wsel)
            WS_DRAW: begin
                wr_addr = draw_addr_reg;
                wr_data = draw_on_reg ? (rd_data_reg | draw_mask_reg)
                                      : (rd_data_reg & ~draw_mask_reg);
            end
            WS_PAGE: wr_addr = {sweep_reg[COL_W-1:0], clr_page_reg};
            WS_ALL:  wr_addr = sweep_reg;
            default: wr_addr = sweep_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result byte
    logic [7:0] byte_val;
    logic       byte_data;
    logic       byte_last;

    always_comb begin
        byte_data = 1'b0;
        if (scan_step_reg == STEP_W'(0)) begin
            byte_val = CMD_PAGE_BASE + 8'(scan_page_reg);
        end else if (scan_step_reg == STEP_W'(1)) begin
            byte_val = CMD_COL_LOW | {4'h0, col_offset[3:0]};
        end else if (scan_step_reg == STEP_W'(2)) begin
            byte_val = CMD_COL_HIGH | {4'h0, col_offset[7:4]};
        end else begin
            byte_val  = rd_data_reg;
            byte_data = 1'b1;
        end
    end

    assign byte_last = (scan_step_reg == STEP_LAST) && (scan_page_reg == PAGE_LAST);

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_data_reg, out_last_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_byte_reg <= byte_val;
            out_data_reg <= byte_data;
            out_last_reg <= byte_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign status.in_op       = in_op;
    assign status.point_ok    = ({1'b0, in_x} < 9'(COLUMNS)) && ({1'b0, in_y} < 9'(PAGES * 8));
    assign status.page_ok     = {1'b0, in_page} < 5'(PAGES);
    assign status.sweep_done  = sweep_done;
    assign status.scan_active = scan_active_reg;
    assign status.out_free    = !out_valid_reg || m_tready;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the monochrome display framebuffer top level.
`timescale 1ns / 100ps

module testbench;
    import mdfb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    // clear screen walks the whole store; settle this long before a register write
    localparam int SETTLE_CYCLES = 1100;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [3:0] page_sel;
        logic       pixel_on;
        logic [7:0] y_pos;
        logic [7:0] x_pos;
        logic [2:0] command;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] link_byte;
        logic       is_data;
        logic       frame_last;
    } link_item_t;

    typedef enum logic [1:0] {FROM_MODEL, NO_BYTE, BYTE_IS} want_kind_t;

    typedef struct {
        cmd_item_t  item;
        want_kind_t kind;
        link_item_t want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [23:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the panel store and scan state
    logic [7:0]        pix_store [COLUMNS * PAGES];
    logic              scan_on;
    logic [PAGE_W-1:0] scan_pg;
    logic [STEP_W-1:0] scan_step;
    logic [7:0]        col_offset;

    link_item_t link_bytes_due [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    bit         src_steady = 1'b0;

    mono_display_framebuffer_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    function automatic cmd_item_t mk(input logic [2:0] op, input int x, input int y,
                                     input bit on, input int ps);
        cmd_item_t c;
        c.command  = op;
        c.x_pos    = 8'(x);
        c.y_pos    = 8'(y);
        c.pixel_on = on;
        c.page_sel = 4'(ps);
        return c;
    endfunction

    function automatic void clear_store();
        for (int i = 0; i < COLUMNS * PAGES; i++) pix_store[i] = 8'h00;
    endfunction

    // Applies one command to the shadow state; returns 1 when it yields a link byte.
    function automatic bit apply_command(input cmd_item_t c, output link_item_t b);
        int col;
        int idx;
        b = '0;
        case (c.command)
            OP_DRAW: begin
                if (c.x_pos < COLUMNS && c.y_pos < PAGES * 8) begin
                    // vertical flip: row 0 lands in the top bit of the last page
                    idx = c.x_pos * PAGES + (PAGES - 1 - c.y_pos / 8);
                    pix_store[idx][7 - (c.y_pos % 8)] = c.pixel_on;
                end
            end
            OP_CLR_PAGE: begin
                if (c.page_sel < PAGES)
                    for (col = 0; col < COLUMNS; col++) pix_store[col * PAGES + c.page_sel] = 8'h00;
            end
            OP_CLR_ALL, OP_REFRESH: begin
                if (c.command == OP_CLR_ALL) clear_store();
                scan_on   = 1'b1;
                scan_pg   = '0;
                scan_step = '0;
            end
            OP_NEXT: begin
                if (!scan_on) return 1'b0;
                if (scan_step == 0) begin
                    b.link_byte = CMD_PAGE_BASE + 8'(scan_pg);
                end else if (scan_step == 1) begin
                    b.link_byte = CMD_COL_LOW | (col_offset & 8'h0F);
                end else if (scan_step == 2) begin
                    b.link_byte = CMD_COL_HIGH | (col_offset >> 4);
                end else begin
                    col = scan_step - HEAD_STEPS;
                    if (col >= COLUMNS) col = COLUMNS - 1;
                    b.link_byte = pix_store[col * PAGES + scan_pg];
                    b.is_data   = 1'b1;
                end
                scan_step = scan_step + 1'b1;
                if (scan_step >= HEAD_STEPS + COLUMNS) begin
                    scan_step = '0;
                    if (scan_pg + 1 >= PAGES) begin
                        b.frame_last = 1'b1;
                        scan_on      = 1'b0;
                        scan_pg      = '0;
                    end else begin
                        scan_pg = scan_pg + 1'b1;
                    end
                end
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic push_item(input cmd_item_t c, input want_kind_t kind, input link_item_t want);
        int gap;
        link_item_t b;
        if ($urandom_range(0, 63) == 0) src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (apply_command(c, b) && kind == FROM_MODEL) link_bytes_due.push_back(b);
        if (kind == BYTE_IS) link_bytes_due.push_back(want);
    endtask

    // frame_run: long runs of next byte with no restart, so whole frames complete
    function automatic cmd_item_t random_item(input bit frame_run);
        cmd_item_t c;
        int pick;
        c = cmd_item_t'(24'($urandom));
        pick = $urandom_range(0, 99);
        if (frame_run) begin
            if (pick < 85) c.command = OP_NEXT;
            else if (pick < 97) c.command = OP_DRAW;
            else if (pick < 99) c.command = OP_CLR_PAGE;
            else c.command = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end else begin
            if (pick < 60) c.command = OP_NEXT;
            else if (pick < 88) c.command = OP_DRAW;
            else if (pick < 93) c.command = OP_CLR_PAGE;
            else if (pick < 94) c.command = OP_CLR_ALL;
            else if (pick < 96) c.command = OP_REFRESH;
            else c.command = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        if (c.command == OP_DRAW && $urandom_range(0, 4) != 0) begin
            c.x_pos = 8'($urandom_range(0, COLUMNS - 1));
            c.y_pos = 8'($urandom_range(0, PAGES * 8 - 1));
        end
        return c;
    endfunction

    // wait for every link byte, then for any clear still walking the store
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (link_bytes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_col_offset(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_COL_OFFSET, 2'b00};
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        col_offset = value;
    endtask

    task automatic random_phase(input int count, input bit frame_run);
        for (int n = 0; n < count; n++) push_item(random_item(frame_run), FROM_MODEL, '0);
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : link_sink
        link_item_t got;
        link_item_t want;
        int gap;
        bit steady;
        steady = 1'b0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 63) == 0) steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = {m_tdata, m_tuser, m_tlast};
            if (link_bytes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected link item: byte %02h data %0d last %0d",
                             got.link_byte, got.is_data, got.frame_last);
            end else begin
                want = link_bytes_due.pop_front();
                if (got.link_byte !== want.link_byte || got.is_data !== want.is_data ||
                    got.frame_last !== want.frame_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("link item mismatch: expected byte %02h data %0d last %0d, got byte %02h data %0d last %0d",
                                 want.link_byte, want.is_data, want.frame_last,
                                 got.link_byte, got.is_data, got.frame_last);
                end
            end
        end
    end

    initial begin : stimulus
        row_t directed_rows [25];
        aresetn  <= 1'b0;
        s_tdata  <= '0;
        s_tvalid <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        clear_store();
        scan_on    = 1'b0;
        scan_pg    = '0;
        scan_step  = '0;
        col_offset = COL_OFFSET_RESET;

        directed_rows = '{
            '{mk(OP_NEXT, 0, 0, 0, 0), NO_BYTE, '0},                 // next byte while idle
            '{mk(OP_UNUSED_LO, 255, 255, 1, 15), NO_BYTE, '0},
            '{mk(OP_UNUSED_HI, 255, 255, 1, 15), NO_BYTE, '0},
            '{mk(OP_DRAW, 0, 0, 1, 0), FROM_MODEL, '0},
            '{mk(OP_DRAW, 127, 63, 1, 0), FROM_MODEL, '0},
            '{mk(OP_DRAW, 128, 0, 1, 0), FROM_MODEL, '0},             // off panel
            '{mk(OP_DRAW, 0, 64, 1, 0), FROM_MODEL, '0},
            '{mk(OP_DRAW, 255, 255, 1, 15), FROM_MODEL, '0},
            '{mk(OP_DRAW, 5, 10, 1, 0), FROM_MODEL, '0},
            '{mk(OP_DRAW, 5, 10, 0, 0), FROM_MODEL, '0},
            '{mk(OP_DRAW, 64, 33, 1, 0), FROM_MODEL, '0},
            '{mk(OP_CLR_PAGE, 0, 0, 0, 15), FROM_MODEL, '0},          // page out of range
            '{mk(OP_CLR_PAGE, 0, 0, 0, 8), FROM_MODEL, '0},
            '{mk(OP_CLR_PAGE, 0, 0, 0, 3), FROM_MODEL, '0},
            '{mk(OP_REFRESH, 0, 0, 0, 0), NO_BYTE, '0},
            '{mk(OP_NEXT, 0, 0, 0, 0), BYTE_IS, '{8'hB0, 1'b0, 1'b0}},
            '{mk(OP_NEXT, 0, 0, 0, 0), BYTE_IS, '{8'h02, 1'b0, 1'b0}},
            '{mk(OP_NEXT, 0, 0, 0, 0), BYTE_IS, '{8'h10, 1'b0, 1'b0}},
            '{mk(OP_NEXT, 255, 255, 1, 15), FROM_MODEL, '0},
            '{mk(OP_REFRESH, 0, 0, 0, 0), NO_BYTE, '0},               // restart mid page
            '{mk(OP_NEXT, 0, 0, 0, 0), BYTE_IS, '{8'hB0, 1'b0, 1'b0}},
            '{mk(OP_CLR_ALL, 0, 0, 0, 0), NO_BYTE, '0},
            '{mk(OP_NEXT, 0, 0, 0, 0), BYTE_IS, '{8'hB0, 1'b0, 1'b0}},
            '{mk(OP_NEXT, 0, 0, 0, 0), BYTE_IS, '{8'h02, 1'b0, 1'b0}},
            '{mk(OP_DRAW, 0, 0, 1, 0), FROM_MODEL, '0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            push_item(directed_rows[i].item, directed_rows[i].kind, directed_rows[i].want);

        drain_and_settle();
        write_col_offset(8'd131);
        push_item(mk(OP_REFRESH, 0, 0, 0, 0), FROM_MODEL, '0);
        random_phase(1300, 1'b1);

        drain_and_settle();
        write_col_offset(8'd0);
        random_phase(400, 1'b0);

        drain_and_settle();
        write_col_offset(8'($urandom_range(1, 130)));
        random_phase(400, 1'b0);

        s_tvalid <= 1'b0;
        while (link_bytes_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (link_bytes_due.size() != 0)
            $display("%0d link items never arrived", link_bytes_due.size());
        if (mismatch_count == 0 && link_bytes_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
